// File: sv/irs_pkg.sv
`default_nettype none

package irs_pkg;

	localparam logic [31:0] INFINITY_BITS = 32'h7F80_0000;
	localparam logic [7:0]  EXP_ALL_ONES  = 8'hFF;

	localparam int REG_IDX_W  = 1;
	localparam int REG_DATA_W = 6;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ENABLE  = 1'b0,
		REG_MIN_RUN = 1'b1
	} reg_idx_t;

	// depths of the command queue and of the result queue
	localparam int OPQ_DEPTH  = 4;
	localparam int OUTQ_DEPTH = 4;

	typedef struct packed {
		logic [31:0] range_bits;
		logic        scan_end;
	} sample_t;

	typedef struct packed {
		logic [31:0] range_out;
		logic        scan_end_out;
		logic        burst_last;
	} result_t;

endpackage

`default_nettype wire

// File: sv/irs_fifo.sv
`default_nettype none

module irs_fifo import irs_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [W-1:0]                 wr_data,
	output logic                              full,
	input  wire logic                         rd_en,
	output logic [W-1:0]                      rd_data,
	output logic                              empty,
	output logic [$clog2(DEPTH+1)-1:0]        count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [W-1:0]  data_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = data_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			data_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// File: sv/irs_front.sv
`default_nettype none

module irs_front import irs_pkg::*; #(
	parameter int MAX_RUN = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [REG_IDX_W-1:0]          wr_index,
	input  wire logic [REG_DATA_W-1:0]         wr_data,
	input  wire logic                          push,
	input  wire sample_t                       sample,
	output logic                               full,
	output logic                               op_push,
	output logic [35+$clog2(MAX_RUN)-1:0]      op_data,
	input  wire logic                          op_full
);

	localparam int IW = $clog2(MAX_RUN);
	localparam int EW = (IW + 1 > REG_DATA_W) ? IW + 1 : REG_DATA_W;

	// store: n is the write index; emit: n held samples, then the current one
	typedef struct packed {
		logic          is_store;
		logic          blank;
		logic          scan_end;
		logic [IW-1:0] n;
		logic [31:0]   bits;
	} op_t;

	logic                  enable_q;
	logic [REG_DATA_W-1:0] min_run_q;
	logic [IW-1:0]         count_q;
	logic                  accepted_q;

	logic                  accept;
	logic                  valid_smp;
	logic [EW-1:0]         min_eff;
	logic [EW-1:0]         min_ext;
	logic [EW-1:0]         new_cnt;
	logic [EW-1:0]         cnt_ext;
	logic                  reached;
	logic                  hold;
	op_t                   op;

	assign full    = op_full;
	assign accept  = push && !op_full;
	assign op_push = accept;
	assign op_data = op;

	assign valid_smp = (sample.range_bits[30:23] != EXP_ALL_ONES);
	assign min_ext   = EW'(min_run_q);
	assign cnt_ext   = EW'(count_q);
	assign new_cnt   = cnt_ext + 1'b1;

	always_comb begin
		if (min_ext == '0) begin
			min_eff = EW'(1);
		end else if (min_ext > EW'(MAX_RUN)) begin
			min_eff = EW'(MAX_RUN);
		end else begin
			min_eff = min_ext;
		end
	end

	assign reached = (new_cnt >= min_eff);
	assign hold    = enable_q && valid_smp && !accepted_q && !reached && !sample.scan_end;

	always_comb begin
		op.is_store = hold;
		op.scan_end = sample.scan_end;
		op.n        = count_q;
		op.bits     = sample.range_bits;
		op.blank    = 1'b0;
		if (!hold && enable_q) begin
			if (!valid_smp) begin
				op.blank = (cnt_ext < min_eff);
			end else if (!accepted_q && !reached) begin
				// run cut short by the end of the scan: blank it all
				op.blank = 1'b1;
				op.bits  = INFINITY_BITS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			min_run_q  <= REG_DATA_W'(1);
			count_q    <= '0;
			accepted_q <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (reg_idx_t'(wr_index))
					REG_ENABLE:  enable_q  <= wr_data[0];
					REG_MIN_RUN: min_run_q <= wr_data;
					default: ;
				endcase
			end
			if (accept) begin
				if (hold) begin
					count_q <= count_q + 1'b1;
				end else begin
					count_q <= '0;
				end
				accepted_q <= enable_q && valid_smp && (accepted_q || reached)
					&& !sample.scan_end;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/irs_back.sv
`default_nettype none

module irs_back import irs_pkg::*; #(
	parameter int MAX_RUN = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [35+$clog2(MAX_RUN)-1:0] op_data,
	input  wire logic                          op_empty,
	output logic                               op_pop,
	output logic                               res_push,
	output result_t                            res_data,
	input  wire logic [$clog2(OUTQ_DEPTH+1)-1:0] res_count
);

	localparam int IW = $clog2(MAX_RUN);
	localparam int QW = $clog2(OUTQ_DEPTH+1) + 1;

	typedef struct packed {
		logic          is_store;
		logic          blank;
		logic          scan_end;
		logic [IW-1:0] n;
		logic [31:0]   bits;
	} op_t;

	logic [31:0]   pend_mem [MAX_RUN];
	op_t           op;
	logic [IW-1:0] step_q;
	logic          credit;
	logic          store_go;
	logic          emit_go;
	logic          at_cur;

	logic          valid_s1;
	logic          from_mem_s1;
	logic          blank_s1;
	logic          last_s1;
	logic          end_s1;
	logic [31:0]   bits_s1;
	logic [31:0]   rdata_s1;

	assign op       = op_data;
	// leave room for the result already in flight
	assign credit   = (QW'(res_count) + QW'(valid_s1)) < QW'(OUTQ_DEPTH);
	assign store_go = !op_empty && op.is_store;
	assign emit_go  = !op_empty && !op.is_store && credit;
	assign at_cur   = (step_q == op.n);
	assign op_pop   = store_go || (emit_go && at_cur);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= emit_go;
			if (emit_go) begin
				step_q <= at_cur ? '0 : step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_go) begin
			pend_mem[op.n] <= op.bits;
		end
		rdata_s1    <= pend_mem[step_q];
		from_mem_s1 <= !at_cur;
		blank_s1    <= op.blank;
		bits_s1     <= op.bits;
		last_s1     <= at_cur;
		end_s1      <= op.scan_end && at_cur;
	end

	always_comb begin
		res_push              = valid_s1;
		res_data.scan_end_out = end_s1;
		res_data.burst_last   = last_s1;
		if (from_mem_s1) begin
			res_data.range_out = blank_s1 ? INFINITY_BITS : rdata_s1;
		end else begin
			res_data.range_out = bits_s1;
		end
	end

endmodule

`default_nettype wire

// File: sv/isolated_run_suppressor.sv
// Channel   | Handshake         | Payload
// ----------+-------------------+-------------------------------------
// sample    | push / full       | sample_t: range_bits, scan_end
// result    | pop / empty       | result_t: range_out, scan_end_out, burst_last
// config    | wr_en             | wr_index, wr_data
//
// The front classifies one sample per cycle while the command queue has room and
// queues a command; full rises only when the command queue is full. A held sample
// is written into the pending memory; an emitting command releases its held samples
// one at a time through the single pending memory read port, then the current sample.
// Each result passes through the s1 registers before it enters the result queue.
// Reset clears the run state and the queues; the pending memory needs no clearing.
`default_nettype none

module isolated_run_suppressor import irs_pkg::*; #(
	parameter int MAX_RUN = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [REG_IDX_W-1:0]  wr_index,
	input  wire logic [REG_DATA_W-1:0] wr_data,
	input  wire logic                  push,
	input  wire sample_t               sample,
	output logic                       full,
	input  wire logic                  pop,
	output result_t                    result,
	output logic                       empty
);

	localparam int OPW = 35 + $clog2(MAX_RUN);
	localparam int RW  = $bits(result_t);

	logic                              op_push;
	logic [OPW-1:0]                    op_wdata;
	logic                              op_full;
	logic                              op_pop;
	logic [OPW-1:0]                    op_rdata;
	logic                              op_empty;
	logic                              res_push;
	result_t                           res_data;
	logic [$clog2(OUTQ_DEPTH+1)-1:0]   res_count;
	logic [RW-1:0]                     res_rdata;

	irs_front #(.MAX_RUN(MAX_RUN)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.push     (push),
		.sample   (sample),
		.full     (full),
		.op_push  (op_push),
		.op_data  (op_wdata),
		.op_full  (op_full)
	);

	irs_fifo #(.W(OPW), .DEPTH(OPQ_DEPTH)) u_opq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (op_push),
		.wr_data (op_wdata),
		.full    (op_full),
		.rd_en   (op_pop),
		.rd_data (op_rdata),
		.empty   (op_empty),
		.count   ()
	);

	irs_back #(.MAX_RUN(MAX_RUN)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_data   (op_rdata),
		.op_empty  (op_empty),
		.op_pop    (op_pop),
		.res_push  (res_push),
		.res_data  (res_data),
		.res_count (res_count)
	);

	irs_fifo #(.W(RW), .DEPTH(OUTQ_DEPTH)) u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_data),
		.full    (),
		.rd_en   (pop),
		.rd_data (res_rdata),
		.empty   (empty),
		.count   (res_count)
	);

	assign result = res_rdata;

endmodule

`default_nettype wire
